@@ hw/rtl/utf8_to_utf16_decoder_assert.svh @@
// Assertion macros for the UTF-8 to UTF-16 decoder.
// Expects a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef UTF8_TO_UTF16_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define U8U16_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define U8U16_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

@@ hw/rtl/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies; used by every module of the block.
package u8u16_pkg;

	localparam int COUNT_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Byte classes produced by the front stage.
	localparam logic [2:0] CLS_ASCII = 3'd0;
	localparam logic [2:0] CLS_LEAD2 = 3'd1;
	localparam logic [2:0] CLS_LEAD3 = 3'd2;
	localparam logic [2:0] CLS_CONT  = 3'd3;
	localparam logic [2:0] CLS_BAD   = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        is_error;
		logic [15:0] unit_count;
		logic        is_last;
	} out_item_t;

	// Classified byte as it travels through the queue.
	typedef struct packed {
		logic [2:0] cls;
		logic [6:0] bits;
		logic       last;
	} token_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

@@ hw/rtl/u8u16_front.sv @@
// Front stage: registers each accepted byte together with its class.
// Depends on u8u16_pkg.
module u8u16_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  u8u16_pkg::in_item_t byte_item,
	output logic                tok_valid,
	input  logic                tok_ready,
	output u8u16_pkg::token_t   tok
);

	logic              valid_s1;
	u8u16_pkg::token_t tok_s1;
	logic [2:0]        cls;

	always_comb begin
		if (byte_item.data_byte[7] == 1'b0) begin
			cls = u8u16_pkg::CLS_ASCII;
		end else if (byte_item.data_byte[7:6] == 2'b10) begin
			cls = u8u16_pkg::CLS_CONT;
		end else if (byte_item.data_byte[7:5] == 3'b110) begin
			cls = u8u16_pkg::CLS_LEAD2;
		end else if (byte_item.data_byte[7:4] == 4'b1110) begin
			cls = u8u16_pkg::CLS_LEAD3;
		end else begin
			cls = u8u16_pkg::CLS_BAD;
		end
	end

	assign byte_ready = !valid_s1 || tok_ready;
	assign tok_valid  = valid_s1;
	assign tok        = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			tok_s1.cls  <= cls;
			tok_s1.bits <= byte_item.data_byte[6:0];
			tok_s1.last <= byte_item.end_of_string;
		end
	end

endmodule

@@ hw/rtl/u8u16_queue.sv @@
// Small first-in first-out queue of classified bytes between front and back.
// Depends on u8u16_pkg.
module u8u16_queue #(
	parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push_valid,
	output logic                       push_ready,
	input  u8u16_pkg::token_t          push_tok,
	output logic                       pop_valid,
	input  logic                       pop_ready,
	output u8u16_pkg::token_t          pop_tok,
	output u8u16_pkg::queue_status_t   status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	u8u16_pkg::token_t entry_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     fill_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (fill_q == CW'(DEPTH));
	assign status.empty = (fill_q == '0);
	assign push_ready   = !status.full;
	assign pop_valid    = !status.empty;
	assign pop_tok      = entry_q[rd_ptr_q];
	assign do_push      = push_valid && push_ready;
	assign do_pop       = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

@@ hw/rtl/u8u16_back.sv @@
// Back stage: assembles code units from classified bytes, counts them and
// holds each result in an output register. Depends on u8u16_pkg.
module u8u16_back #(
	parameter int COUNT_BITS = u8u16_pkg::COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tok_valid,
	output logic                 tok_ready,
	input  u8u16_pkg::token_t    tok,
	output logic                 unit_valid,
	input  logic                 unit_ready,
	output u8u16_pkg::out_item_t unit_item
);

	localparam int WW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	logic [15:0]           partial_q;
	logic [1:0]            pending_q;
	logic                  error_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  out_valid_q;
	u8u16_pkg::out_item_t  out_q;

	logic [15:0]           partial_d;
	logic [1:0]            pending_d;
	logic                  error_d;
	logic [COUNT_BITS-1:0] count_d;
	logic [15:0]           unit_d;
	logic                  done;
	logic                  emit;
	logic                  bad;
	logic [WW-1:0]         count_wide;
	logic [15:0]           count_rep;
	logic                  take;

	assign tok_ready = !out_valid_q || unit_ready;
	assign take      = tok_valid && tok_ready;

	always_comb begin
		partial_d = partial_q;
		pending_d = pending_q;
		error_d   = error_q;
		count_d   = count_q;
		unit_d    = '0;
		done      = 1'b0;
		if (!error_q) begin
			if (pending_q == 2'd0) begin
				case (tok.cls)
					u8u16_pkg::CLS_ASCII: begin
						unit_d = {9'd0, tok.bits};
						done   = 1'b1;
					end
					u8u16_pkg::CLS_LEAD2: begin
						partial_d = {5'd0, tok.bits[4:0], 6'd0};
						pending_d = 2'd1;
					end
					u8u16_pkg::CLS_LEAD3: begin
						partial_d = {tok.bits[3:0], 12'd0};
						pending_d = 2'd2;
					end
					default: begin
						error_d = 1'b1;
					end
				endcase
			end else if (tok.cls != u8u16_pkg::CLS_CONT) begin
				error_d = 1'b1;
			end else if (pending_q == 2'd2) begin
				partial_d = partial_q | {4'd0, tok.bits[5:0], 6'd0};
				pending_d = 2'd1;
			end else begin
				unit_d    = partial_q | {10'd0, tok.bits[5:0]};
				partial_d = '0;
				pending_d = 2'd0;
				done      = 1'b1;
			end
			if (done && (count_q != {COUNT_BITS{1'b1}})) begin
				count_d = count_q + COUNT_BITS'(1);
			end
		end
		count_wide = WW'(count_d);
		count_rep  = (count_wide > WW'(16'hFFFF)) ? 16'hFFFF : count_wide[15:0];
		bad        = error_d || (pending_d != 2'd0);
		emit       = done || tok.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			pending_q   <= '0;
			error_q     <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= emit;
			if (tok.last) begin
				partial_q <= '0;
				pending_q <= '0;
				error_q   <= 1'b0;
				count_q   <= '0;
			end else begin
				partial_q <= partial_d;
				pending_q <= pending_d;
				error_q   <= error_d;
				count_q   <= count_d;
			end
		end else if (unit_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			if (tok.last && bad) begin
				out_q.code_unit  <= '0;
				out_q.is_error   <= 1'b1;
				out_q.unit_count <= '0;
			end else begin
				out_q.code_unit  <= unit_d;
				out_q.is_error   <= 1'b0;
				out_q.unit_count <= count_rep;
			end
			out_q.is_last <= tok.last;
		end
	end

	assign unit_valid = out_valid_q;
	assign unit_item  = out_q;

endmodule

@@ hw/rtl/utf8_to_utf16_decoder.sv @@
// Top level of the UTF-8 to UTF-16 decoder: front stage, queue, back stage.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back and the assert header.
//
//   Channel  Direction  Handshake                 Payload
//   byte     in         byte_valid / byte_ready   u8u16_pkg::in_item_t  (one string byte)
//   unit     out        unit_valid / unit_ready   u8u16_pkg::out_item_t (code unit or end)
//
// The block takes one byte per cycle when the result side keeps up.
// An accepted byte passes through the front register and the queue to the back
// stage, and its result, if any, is presented from the output register.
// Reset (arst_n low) empties the queue and returns the decoder to the start
// of a string with a zero unit count.
// A stalled result side fills the output register, then the queue, then the
// front register before byte_ready falls; nothing is lost on either side.
`include "utf8_to_utf16_decoder_assert.svh"

module utf8_to_utf16_decoder #(
	parameter int COUNT_BITS  = u8u16_pkg::COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  u8u16_pkg::in_item_t  byte_item,
	output logic                 unit_valid,
	input  logic                 unit_ready,
	output u8u16_pkg::out_item_t unit_item
);

	// Front to queue: classified bytes, one request per accepted byte.
	logic                     front_valid;
	logic                     front_ready;
	u8u16_pkg::token_t        front_tok;

	// Queue to back.
	logic                     back_valid;
	logic                     back_ready;
	u8u16_pkg::token_t        back_tok;
	u8u16_pkg::queue_status_t q_status;

	// The front stage sorts each byte into ASCII, lead of two, lead of three,
	// continuation or invalid lead, so the back stage only assembles bits.
	u8u16_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.tok_valid  (front_valid),
		.tok_ready  (front_ready),
		.tok        (front_tok)
	);

	// The queue decouples the two halves so a short stall at the result side
	// does not reach the byte side at once.
	u8u16_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_tok   (front_tok),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_tok    (back_tok),
		.status     (q_status)
	);

	// The back stage keeps the partial unit, the number of continuation bytes
	// still expected, the sticky error flag and the saturating unit count.
	// At the final byte it reports either the last unit or an error, then
	// clears all of that state for the next string.
	u8u16_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (back_valid),
		.tok_ready  (back_ready),
		.tok        (back_tok),
		.unit_valid (unit_valid),
		.unit_ready (unit_ready),
		.unit_item  (unit_item)
	);

	// An accepted byte must be held by the front register on the next cycle.
	`U8U16_ASSERT_NEXT(a_front_holds, byte_valid && byte_ready, front_valid, "byte not captured")
	// The queue cannot be full and empty at once.
	`U8U16_ASSERT_ALWAYS(a_queue_sane, !(q_status.full && q_status.empty), "queue status broken")
	// An error is only ever reported on the final result of a string.
	`U8U16_ASSERT_ALWAYS(a_error_last, !(unit_valid && unit_item.is_error) || unit_item.is_last, "error not on last result")
	// An error result carries neither a unit nor a count.
	`U8U16_ASSERT_ALWAYS(a_error_zero, !(unit_valid && unit_item.is_error) || (unit_item.code_unit == 16'd0 && unit_item.unit_count == 16'd0), "error result not cleared")

endmodule

@@ tb/sv/utf8_to_utf16_decoder_tb.sv @@
// Testbench for utf8_to_utf16_decoder: drives UTF-8 strings byte by byte and checks
// every code unit and string end against a decoder model kept in a scoreboard class.
// Depends on u8u16_pkg and the utf8_to_utf16_decoder RTL only.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_tb;
	import u8u16_pkg::*;

	// The count register width of the block as instantiated here.
	localparam int COUNT_BITS = COUNT_BITS_DEF;
	localparam int NUM_RANDOM_BYTES = 450;
	// The limit lies well above the length of the slowest correct run.
	localparam int unsigned CYCLE_LIMIT = 100000;
	// How long the result side holds off while the sender keeps pushing.
	localparam int HOLD_CYCLES = 80;
	// Cycles allowed after the last expected result before the run is closed.
	localparam int DRAIN_CYCLES = 16;

	// Shapes of random strings.
	typedef enum int {
		STR_VALID,
		STR_BAD_LEAD,
		STR_BAD_CONT,
		STR_TRUNCATED,
		STR_NOISE
	} string_kind_e;

	// Stall styles of the result side.
	typedef enum int {
		RX_ALWAYS,
		RX_MOSTLY,
		RX_SELDOM,
		RX_PERIODIC
	} rx_style_e;

	// Keeps its own copy of the decoder state, predicts the result of every
	// accepted byte request and compares result requests in order.
	class unit_scoreboard;
		logic [15:0]           partial;
		logic [1:0]            conts_left;
		bit                    malformed;
		logic [COUNT_BITS-1:0] units_so_far;
		out_item_t             expected_units[$];
		int unsigned           mismatches;
		int unsigned           units_checked;
		int unsigned           ends_checked;
		int unsigned           error_ends;

		function new();
			clear_string();
			mismatches = 0;
			units_checked = 0;
			ends_checked = 0;
			error_ends = 0;
		endfunction

		function void clear_string();
			partial = '0;
			conts_left = '0;
			malformed = 1'b0;
			units_so_far = '0;
		endfunction

		function int pending_count();
			return expected_units.size();
		endfunction

		// Decodes one accepted byte request and queues the result it causes.
		function void decode_byte(in_item_t req);
			logic [7:0]  b;
			logic [15:0] unit;
			logic [15:0] shown_count;
			bit          done;
			bit          bad;
			out_item_t   res;
			b = req.data_byte;
			unit = '0;
			done = 1'b0;
			if (!malformed) begin
				if (conts_left == 2'd0) begin
					if (b[7] == 1'b0) begin
						unit = {8'h00, b};
						done = 1'b1;
					end else if (b[7:5] == 3'b110) begin
						partial = {5'b0, b[4:0], 6'b0};
						conts_left = 2'd1;
					end else if (b[7:4] == 4'b1110) begin
						partial = {b[3:0], 12'b0};
						conts_left = 2'd2;
					end else begin
						malformed = 1'b1;
					end
				end else if (b[7:6] != 2'b10) begin
					malformed = 1'b1;
				end else begin
					if (conts_left == 2'd2)
						partial = partial | {4'b0, b[5:0], 6'b0};
					else
						partial = partial | {10'b0, b[5:0]};
					conts_left = conts_left - 2'd1;
					if (conts_left == 2'd0) begin
						unit = partial;
						partial = '0;
						done = 1'b1;
					end
				end
				// The count sticks at its top value.
				if (done && units_so_far != {COUNT_BITS{1'b1}})
					units_so_far = units_so_far + 1'b1;
			end
			if (units_so_far > 'hFFFF)
				shown_count = 16'hFFFF;
			else
				shown_count = 16'(units_so_far);
			if (req.end_of_string) begin
				// The final byte always answers, with an error if the string went wrong
				// anywhere or stopped in the middle of a sequence.
				bad = malformed || conts_left != 2'd0;
				res.code_unit = bad ? 16'h0000 : unit;
				res.is_error = bad;
				res.unit_count = bad ? 16'h0000 : shown_count;
				res.is_last = 1'b1;
				expected_units.push_back(res);
				clear_string();
			end else if (done) begin
				res.code_unit = unit;
				res.is_error = 1'b0;
				res.unit_count = shown_count;
				res.is_last = 1'b0;
				expected_units.push_back(res);
			end
		endfunction

		// Compares one accepted result request with the oldest prediction.
		function void check_unit(out_item_t got);
			out_item_t want;
			if (expected_units.size() == 0) begin
				$error("unexpected result: code_unit %h is_error %0b unit_count %0d is_last %0b",
					got.code_unit, got.is_error, got.unit_count, got.is_last);
				mismatches++;
				return;
			end
			want = expected_units.pop_front();
			if (got.code_unit !== want.code_unit) begin
				$error("code_unit: expected %h, actual %h", want.code_unit, got.code_unit);
				mismatches++;
			end
			if (got.is_error !== want.is_error) begin
				$error("is_error: expected %0b, actual %0b", want.is_error, got.is_error);
				mismatches++;
			end
			if (got.unit_count !== want.unit_count) begin
				$error("unit_count: expected %0d, actual %0d", want.unit_count, got.unit_count);
				mismatches++;
			end
			if (got.is_last !== want.is_last) begin
				$error("is_last: expected %0b, actual %0b", want.is_last, got.is_last);
				mismatches++;
			end
			if (want.is_last) begin
				ends_checked++;
				if (want.is_error)
					error_ends++;
			end else begin
				units_checked++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      byte_valid;
	logic      byte_ready;
	in_item_t  byte_item;
	logic      unit_valid;
	logic      unit_ready;
	out_item_t unit_item;

	unit_scoreboard sb = new();

	// Bytes of the string under construction, sent front to back.
	logic [7:0]  str_q[$];
	int unsigned bytes_sent;
	int unsigned strings_sent;
	// Sender pacing: bursts of requests separated by idle gaps, unless steady.
	int unsigned tx_burst_left;
	bit          tx_steady;
	// Result side control set by the stimulus thread.
	bit          hold_asked;

	utf8_to_utf16_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.unit_valid (unit_valid),
		.unit_ready (unit_ready),
		.unit_item  (unit_item)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Both channels are sampled at the rising edge, before any of the
	// nonblocking updates of that edge land. The byte request is noted first so
	// that a prediction always exists before its result could be checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && byte_ready)
				sb.decode_byte(byte_item);
			if (unit_valid && unit_ready)
				sb.check_unit(unit_item);
		end
	end

	// Result side. Each stretch picks a stall style at random; the stimulus
	// thread can also ask for one long hold-off, counted here, so that the
	// block backs up all the way to its input.
	initial begin
		int unsigned stretch_left;
		int unsigned hold_left;
		int unsigned phase;
		rx_style_e   style;
		logic        rdy;
		stretch_left = 0;
		hold_left = 0;
		phase = 0;
		style = RX_ALWAYS;
		unit_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked) begin
				hold_asked = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (stretch_left == 0) begin
				style = rx_style_e'($urandom_range(0, 3));
				stretch_left = $urandom_range(16, 120);
			end
			stretch_left--;
			phase++;
			if (hold_left != 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (style)
					RX_ALWAYS: rdy = 1'b1;
					RX_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
					RX_SELDOM: rdy = ($urandom_range(0, 3) == 0);
					default: rdy = ((phase % 8) >= 3);
				endcase
			end
			unit_ready <= rdy;
		end
	end

	// Watchdog: a run that is still going at the limit has hung.
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Offers one byte request and returns at the edge where it is accepted.
	// Between bursts valid drops for a random gap; in steady mode it never does.
	task automatic offer_byte(input logic [7:0] b, input logic eos);
		in_item_t req;
		if (!tx_steady && tx_burst_left == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			tx_burst_left = $urandom_range(1, 24);
		end
		if (tx_burst_left != 0)
			tx_burst_left--;
		req.data_byte = b;
		req.end_of_string = eos;
		byte_item <= req;
		byte_valid <= 1'b1;
		do
			@(posedge clk);
		while (!byte_ready);
		bytes_sent++;
	endtask

	// Sends the string in str_q with its final byte marked, then clears it.
	task automatic send_string();
		foreach (str_q[i])
			offer_byte(str_q[i], i == str_q.size() - 1);
		str_q.delete();
		strings_sent++;
	endtask

	// Appends one code unit in 1-, 2- or 3-byte form. Short units in a long
	// form give the overlong encodings, which the block accepts.
	function automatic void add_unit(input int form, input logic [15:0] u);
		if (form == 0) begin
			str_q.push_back({1'b0, u[6:0]});
		end else if (form == 1) begin
			str_q.push_back({3'b110, u[10:6]});
			str_q.push_back({2'b10, u[5:0]});
		end else begin
			str_q.push_back({4'b1110, u[15:12]});
			str_q.push_back({2'b10, u[11:6]});
			str_q.push_back({2'b10, u[5:0]});
		end
	endfunction

	function automatic void add_valid_units(input int count);
		int form;
		for (int i = 0; i < count; i++) begin
			form = $urandom_range(0, 2);
			if (form == 0)
				add_unit(form, 16'($urandom_range(0, 127)));
			else if (form == 1)
				add_unit(form, 16'($urandom_range(0, 2047)));
			else
				add_unit(form, 16'($urandom_range(0, 65535)));
		end
	endfunction

	// A byte that can never start a sequence: a continuation or 1111xxxx.
	function automatic logic [7:0] bad_lead_byte();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(8'h80, 8'hBF));
		return 8'($urandom_range(8'hF0, 8'hFF));
	endfunction

	// A byte that is not a continuation where one is expected.
	function automatic logic [7:0] non_cont_byte();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(8'h00, 8'h7F));
		return 8'($urandom_range(8'hC0, 8'hFF));
	endfunction

	function automatic logic [7:0] multi_lead_byte(input bit three);
		if (three)
			return 8'($urandom_range(8'hE0, 8'hEF));
		return 8'($urandom_range(8'hC0, 8'hDF));
	endfunction

	// Builds one random string. Most are well formed with random content so
	// that the decoder gets deep into multi-byte sequences; the rest break in
	// one of the ways the block must flag, or are plain noise.
	function automatic void build_random_string();
		string_kind_e kind;
		int pick;
		bit three;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			kind = STR_VALID;
		else if (pick == 6)
			kind = STR_BAD_LEAD;
		else if (pick == 7)
			kind = STR_BAD_CONT;
		else if (pick == 8)
			kind = STR_TRUNCATED;
		else
			kind = STR_NOISE;
		case (kind)
			STR_VALID: begin
				add_valid_units($urandom_range(1, 8));
			end
			STR_BAD_LEAD: begin
				add_valid_units($urandom_range(0, 4));
				str_q.insert($urandom_range(0, str_q.size()), bad_lead_byte());
				add_valid_units($urandom_range(0, 2));
			end
			STR_BAD_CONT: begin
				add_valid_units($urandom_range(0, 3));
				three = $urandom_range(0, 1);
				str_q.push_back(multi_lead_byte(three));
				if (three && $urandom_range(0, 1) == 1)
					str_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
				str_q.push_back(non_cont_byte());
				add_valid_units($urandom_range(0, 3));
			end
			STR_TRUNCATED: begin
				add_valid_units($urandom_range(0, 3));
				three = $urandom_range(0, 1);
				str_q.push_back(multi_lead_byte(three));
				if (three && $urandom_range(0, 1) == 1)
					str_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end
			default: begin
				repeat ($urandom_range(1, 12))
					str_q.push_back(8'($urandom_range(0, 255)));
			end
		endcase
	endfunction

	// Long hold-off on the result side while the sender offers a steady
	// stream, so the output register, the queue and the front stage all fill
	// and byte_ready has to fall.
	task automatic squeeze_pipeline();
		tx_steady = 1'b1;
		hold_asked = 1'b1;
		add_valid_units(40);
		send_string();
		tx_steady = 1'b0;
	endtask

	initial begin
		int unsigned random_start;
		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		byte_item <= '0;
		bytes_sent = 0;
		strings_sent = 0;
		tx_burst_left = 0;
		tx_steady = 1'b0;
		hold_asked = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings: the extremes of each sequence length, a surrogate,
		// and each way a string can go wrong.
		str_q = '{8'h00, 8'h7F};
		send_string();
		// Overlong zero and the largest two-byte unit.
		str_q = '{8'hC0, 8'h80, 8'hDF, 8'hBF};
		send_string();
		// Overlong zero and the largest three-byte unit.
		str_q = '{8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF};
		send_string();
		// A lone high surrogate, accepted as it stands.
		str_q = '{8'hED, 8'hA0, 8'h80};
		send_string();
		// Continuation byte in lead position, then more text.
		str_q = '{8'h80, 8'h41};
		send_string();
		// Invalid byte 0xFF as the only and final byte.
		str_q = '{8'hFF};
		send_string();
		// Two-byte lead followed by plain ASCII.
		str_q = '{8'hC2, 8'h41, 8'h42};
		send_string();
		// Three-byte sequence cut off by the end of the string.
		str_q = '{8'hE2, 8'h82};
		send_string();

		// Random strings, with forced back-ups of the pipeline.
		random_start = bytes_sent;
		squeeze_pipeline();
		while (bytes_sent - random_start < NUM_RANDOM_BYTES) begin
			// Now and then a string goes out with no gaps at all.
			tx_steady = ($urandom_range(0, 3) == 0);
			build_random_string();
			send_string();
			if (bytes_sent - random_start > NUM_RANDOM_BYTES / 2 && hold_asked == 1'b0
					&& $urandom_range(0, 15) == 0)
				squeeze_pipeline();
		end
		tx_steady = 1'b0;
		byte_valid <= 1'b0;

		// Let every predicted result arrive, then give stray results a chance
		// to show up before closing.
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d strings, with bursty input and stalled output.",
			bytes_sent, strings_sent);
		$display("Checked %0d code units and %0d string ends, %0d of the ends malformed.",
			sb.units_checked, sb.ends_checked, sb.error_ends);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_front.sv
hw/rtl/u8u16_queue.sv
hw/rtl/u8u16_back.sv
hw/rtl/utf8_to_utf16_decoder.sv
tb/sv/utf8_to_utf16_decoder_tb.sv
